### design/khpt_pkg.sv
// Shared constants, codes and types of the keyed hourly peak table.
// Used by khpt_seq, the top level and the testbench; depends on nothing.
package khpt_pkg;

   localparam int ENTRY_SLOTS = 32;
   localparam int HOUR_SLOTS  = 24;
   localparam int SLOT_DEPTH  = ENTRY_SLOTS * HOUR_SLOTS;

   localparam int EIDX_W  = $clog2(ENTRY_SLOTS);
   localparam int CNT_W   = $clog2(ENTRY_SLOTS + 1);
   localparam int NSLOT_W = $clog2(HOUR_SLOTS + 1);
   localparam int SADDR_W = $clog2(SLOT_DEPTH);

   localparam int ID_W    = 16;
   localparam int KEY_W   = 2 * ID_W;
   localparam int HOUR_W  = 5;
   localparam int PEAK_W  = 24;
   localparam int IDX_W   = 5;
   localparam int USED_W  = 6;

   localparam int ENTRY_W = KEY_W + NSLOT_W;
   localparam int SLOT_W  = HOUR_W + PEAK_W;

   typedef enum logic [1:0] {
      OP_RECORD = 2'd0,
      OP_CLEAR  = 2'd1,
      OP_READ   = 2'd2,
      OP_NOP    = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_TABLE_FULL = 2'd1,
      ST_SLOTS_FULL = 2'd2,
      ST_READ_EMPTY = 2'd3
   } status_type;

   typedef struct packed {
      logic               we;
      logic [EIDX_W-1:0]  waddr;
      logic [ENTRY_W-1:0] wdata;
      logic [EIDX_W-1:0]  raddr;
   } entry_mem_type;

   typedef struct packed {
      logic               we;
      logic [SADDR_W-1:0] waddr;
      logic [SLOT_W-1:0]  wdata;
      logic [SADDR_W-1:0] raddr;
   } slot_mem_type;

   typedef struct packed {
      status_type        status;
      logic [ID_W-1:0]   region;
      logic [ID_W-1:0]   world;
      logic [HOUR_W-1:0] hour;
      logic [PEAK_W-1:0] peak;
      logic [USED_W-1:0] used;
   } result_type;

   function automatic logic [SADDR_W-1:0] slot_addr(input logic [EIDX_W-1:0] e,
                                                    input logic [NSLOT_W-1:0] s);
      slot_addr = SADDR_W'(e * HOUR_SLOTS) + SADDR_W'(s);
   endfunction

endpackage

### design/khpt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module khpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### design/khpt_seq.sv
// Sequencer of the keyed hourly peak table: entry scan, slot scan, update, read.
// Depends on khpt_pkg; drives the entry and slot memories.
module khpt_seq (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_opcode,
   input  logic [15:0]                  req_region_id,
   input  logic [15:0]                  req_world_id,
   input  logic [4:0]                   req_hour_of_day,
   input  logic [23:0]                  req_online_count,
   input  logic [4:0]                   req_entry_index,
   input  logic [4:0]                   req_slot_index,
   output khpt_pkg::entry_mem_type      entry_mem,
   input  logic [khpt_pkg::ENTRY_W-1:0] entry_rdata,
   output khpt_pkg::slot_mem_type       slot_mem,
   input  logic [khpt_pkg::SLOT_W-1:0]  slot_rdata,
   output logic                         res_valid,
   input  logic                         res_ready,
   output khpt_pkg::result_type         res
);

   import khpt_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_ESCAN = 5'b00010,
      S_SSCAN = 5'b00100,
      S_READ  = 5'b01000,
      S_RESP  = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   ea_ff, ea_in;
   logic [EIDX_W-1:0]  ec_ff, ec_in;
   logic               erd_v_ff, erd_v_in;
   logic [NSLOT_W-1:0] sa_ff, sa_in;
   logic [SADDR_W-1:0] sc_ff, sc_in;
   logic               srd_v_ff, srd_v_in;
   logic [EIDX_W-1:0]  e_ff, e_in;
   logic [NSLOT_W-1:0] nslot_ff, nslot_in;
   logic [SADDR_W-1:0] base_ff, base_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [HOUR_W-1:0]  hr_ff, hr_in;
   logic [PEAK_W-1:0]  cnt_ff, cnt_in;
   logic [IDX_W-1:0]   sidx_ff, sidx_in;
   status_type         rst_ff, rst_in;
   logic [KEY_W-1:0]   rkey_ff, rkey_in;
   logic [HOUR_W-1:0]  rhr_ff, rhr_in;
   logic [PEAK_W-1:0]  rpk_ff, rpk_in;

   logic [KEY_W-1:0]   ent_key;
   logic [NSLOT_W-1:0] ent_nslot;
   logic [HOUR_W-1:0]  slt_hour;
   logic [PEAK_W-1:0]  slt_peak;
   logic               ehit, shit;
   logic [NSLOT_W-1:0] rd_slot;
   logic [SADDR_W-1:0] saddr_next;

   assign ent_key   = entry_rdata[ENTRY_W-1 -: KEY_W];
   assign ent_nslot = entry_rdata[NSLOT_W-1:0];
   assign slt_hour  = slot_rdata[SLOT_W-1 -: HOUR_W];
   assign slt_peak  = slot_rdata[PEAK_W-1:0];
   assign ehit      = erd_v_ff && (ent_nslot != '0) && (ent_key == key_ff);
   assign shit      = srd_v_ff && (slt_hour == hr_ff);
   assign rd_slot   = (32'(req_slot_index) < HOUR_SLOTS) ? NSLOT_W'(req_slot_index) : '0;
   assign saddr_next = base_ff + SADDR_W'(sa_ff);

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_RESP);

   always_comb begin
      res.status = rst_ff;
      res.region = rkey_ff[KEY_W-1 -: ID_W];
      res.world  = rkey_ff[ID_W-1:0];
      res.hour   = rhr_ff;
      res.peak   = rpk_ff;
      res.used   = USED_W'(count_ff);
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ea_in    = ea_ff;
      ec_in    = ec_ff;
      erd_v_in = 1'b0;
      sa_in    = sa_ff;
      sc_in    = sc_ff;
      srd_v_in = 1'b0;
      e_in     = e_ff;
      nslot_in = nslot_ff;
      base_in  = base_ff;
      key_in   = key_ff;
      hr_in    = hr_ff;
      cnt_in   = cnt_ff;
      sidx_in  = sidx_ff;
      rst_in   = rst_ff;
      rkey_in  = rkey_ff;
      rhr_in   = rhr_ff;
      rpk_in   = rpk_ff;

      entry_mem.we    = 1'b0;
      entry_mem.waddr = e_ff;
      entry_mem.wdata = {key_ff, nslot_ff};
      entry_mem.raddr = ea_ff[EIDX_W-1:0];
      slot_mem.we     = 1'b0;
      slot_mem.waddr  = sc_ff;
      slot_mem.wdata  = {hr_ff, cnt_ff};
      slot_mem.raddr  = saddr_next;

      unique case (state_ff)
         S_IDLE: begin
            entry_mem.raddr = EIDX_W'(req_entry_index);
            slot_mem.raddr  = slot_addr(EIDX_W'(req_entry_index), rd_slot);
            key_in  = {req_region_id, req_world_id};
            hr_in   = req_hour_of_day;
            cnt_in  = req_online_count;
            sidx_in = req_slot_index;
            ea_in   = '0;
            rst_in  = ST_OK;
            rkey_in = '0;
            rhr_in  = '0;
            rpk_in  = '0;
            if (req_valid) begin
               unique case (opcode_type'(req_opcode))
                  OP_RECORD: state_in = S_ESCAN;
                  OP_CLEAR: begin
                     count_in = '0;
                     state_in = S_RESP;
                  end
                  OP_READ: begin
                     if (CNT_W'(req_entry_index) < count_ff) begin
                        state_in = S_READ;
                     end else begin
                        rst_in   = ST_READ_EMPTY;
                        state_in = S_RESP;
                     end
                  end
                  OP_NOP: state_in = S_RESP;
                  default: state_in = S_RESP;
               endcase
            end
         end

         S_ESCAN: begin
            priority if (ehit) begin
               e_in     = ec_ff;
               nslot_in = ent_nslot;
               base_in  = slot_addr(ec_ff, '0);
               sa_in    = '0;
               state_in = S_SSCAN;
            end else if (ea_ff < count_ff) begin
               entry_mem.raddr = ea_ff[EIDX_W-1:0];
               erd_v_in = 1'b1;
               ec_in    = ea_ff[EIDX_W-1:0];
               ea_in    = ea_ff + 1'b1;
            end else if (32'(count_ff) >= ENTRY_SLOTS) begin
               rst_in   = ST_TABLE_FULL;
               rkey_in  = key_ff;
               rhr_in   = hr_ff;
               rpk_in   = '0;
               state_in = S_RESP;
            end else begin
               entry_mem.we    = 1'b1;
               entry_mem.waddr = count_ff[EIDX_W-1:0];
               entry_mem.wdata = {key_ff, NSLOT_W'(1)};
               slot_mem.we     = 1'b1;
               slot_mem.waddr  = slot_addr(count_ff[EIDX_W-1:0], '0);
               slot_mem.wdata  = {hr_ff, cnt_ff};
               count_in = count_ff + 1'b1;
               rst_in   = ST_OK;
               rkey_in  = key_ff;
               rhr_in   = hr_ff;
               rpk_in   = cnt_ff;
               state_in = S_RESP;
            end
         end

         S_SSCAN: begin
            priority if (shit) begin
               slot_mem.we    = (slt_peak < cnt_ff);
               slot_mem.waddr = sc_ff;
               slot_mem.wdata = {hr_ff, cnt_ff};
               rst_in   = ST_OK;
               rkey_in  = key_ff;
               rhr_in   = hr_ff;
               rpk_in   = (slt_peak < cnt_ff) ? cnt_ff : slt_peak;
               state_in = S_RESP;
            end else if (sa_ff < nslot_ff) begin
               slot_mem.raddr = saddr_next;
               srd_v_in = 1'b1;
               sc_in    = saddr_next;
               sa_in    = sa_ff + 1'b1;
            end else if (32'(nslot_ff) >= HOUR_SLOTS) begin
               rst_in   = ST_SLOTS_FULL;
               rkey_in  = key_ff;
               rhr_in   = hr_ff;
               rpk_in   = '0;
               state_in = S_RESP;
            end else begin
               slot_mem.we     = 1'b1;
               slot_mem.waddr  = saddr_next;
               slot_mem.wdata  = {hr_ff, cnt_ff};
               entry_mem.we    = 1'b1;
               entry_mem.waddr = e_ff;
               entry_mem.wdata = {key_ff, nslot_ff + 1'b1};
               rst_in   = ST_OK;
               rkey_in  = key_ff;
               rhr_in   = hr_ff;
               rpk_in   = cnt_ff;
               state_in = S_RESP;
            end
         end

         S_READ: begin
            if ((32'(sidx_ff) >= HOUR_SLOTS) || (32'(sidx_ff) >= 32'(ent_nslot))) begin
               rst_in  = ST_READ_EMPTY;
               rkey_in = '0;
               rhr_in  = '0;
               rpk_in  = '0;
            end else begin
               rst_in  = ST_OK;
               rkey_in = ent_key;
               rhr_in  = slt_hour;
               rpk_in  = slt_peak;
            end
            state_in = S_RESP;
         end

         S_RESP: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         erd_v_ff <= 1'b0;
         srd_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         erd_v_ff <= erd_v_in;
         srd_v_ff <= srd_v_in;
      end
   end

   always_ff @(posedge clock) begin
      ea_ff    <= ea_in;
      ec_ff    <= ec_in;
      sa_ff    <= sa_in;
      sc_ff    <= sc_in;
      e_ff     <= e_in;
      nslot_ff <= nslot_in;
      base_ff  <= base_in;
      key_ff   <= key_in;
      hr_ff    <= hr_in;
      cnt_ff   <= cnt_in;
      sidx_ff  <= sidx_in;
      rst_ff   <= rst_in;
      rkey_ff  <= rkey_in;
      rhr_ff   <= rhr_in;
      rpk_ff   <= rpk_in;
   end

endmodule

### design/keyed_hourly_peak_table.sv
// Top level of the keyed hourly peak table: sequencer, entry and slot memories,
// response register. Depends on khpt_pkg, khpt_seq and khpt_ram.
//
//   channel   ports                          direction
//   request   req_valid / req_ready / req_*  in
//   response  rsp_valid / rsp_ready / rsp_*  out
//
// Record scans the entries in use, and then the hour slots of the entry it finds, one per cycle
// through each memory's registered read. Clear, no-op and read need no scan; every
// response then passes through the response register.
// Reset is synchronous and empties the table at once; memory contents need no clearing.
// A request is taken while the previous response still waits; a stalled response
// holds the sequencer in its final state until the response register frees.
module keyed_hourly_peak_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [15:0] req_region_id,
   input  logic [15:0] req_world_id,
   input  logic [4:0]  req_hour_of_day,
   input  logic [23:0] req_online_count,
   input  logic [4:0]  req_entry_index,
   input  logic [4:0]  req_slot_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_out_region,
   output logic [15:0] rsp_out_world,
   output logic [4:0]  rsp_out_hour,
   output logic [23:0] rsp_out_peak,
   output logic [5:0]  rsp_entries_used
);

   import khpt_pkg::*;

   entry_mem_type      entry_mem;
   slot_mem_type       slot_mem;
   logic [ENTRY_W-1:0] entry_rdata;
   logic [SLOT_W-1:0]  slot_rdata;
   logic               res_valid;
   logic               res_ready;
   result_type         res;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff, rsp_in;

   khpt_seq u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_region_id    (req_region_id),
      .req_world_id     (req_world_id),
      .req_hour_of_day  (req_hour_of_day),
      .req_online_count (req_online_count),
      .req_entry_index  (req_entry_index),
      .req_slot_index   (req_slot_index),
      .entry_mem        (entry_mem),
      .entry_rdata      (entry_rdata),
      .slot_mem         (slot_mem),
      .slot_rdata       (slot_rdata),
      .res_valid        (res_valid),
      .res_ready        (res_ready),
      .res              (res)
   );

   khpt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ENTRY_SLOTS)
   ) u_entry_ram (
      .clock (clock),
      .we    (entry_mem.we),
      .waddr (entry_mem.waddr),
      .wdata (entry_mem.wdata),
      .raddr (entry_mem.raddr),
      .rdata (entry_rdata)
   );

   khpt_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (SLOT_DEPTH)
   ) u_slot_ram (
      .clock (clock),
      .we    (slot_mem.we),
      .waddr (slot_mem.waddr),
      .wdata (slot_mem.wdata),
      .raddr (slot_mem.raddr),
      .rdata (slot_rdata)
   );

   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      priority if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_ff.status;
   assign rsp_out_region   = rsp_ff.region;
   assign rsp_out_world    = rsp_ff.world;
   assign rsp_out_hour     = rsp_ff.hour;
   assign rsp_out_peak     = rsp_ff.peak;
   assign rsp_entries_used = rsp_ff.used;

endmodule

### tb/keyed_hourly_peak_table_test.sv
// Self-checking testbench for keyed_hourly_peak_table: directed and random requests,
// a local table model for the expected responses, random idling on both channels.
// Depends on khpt_pkg and keyed_hourly_peak_table.
module keyed_hourly_peak_table_test;
   import khpt_pkg::*;

   typedef struct packed {
      opcode_type        op;
      logic [ID_W-1:0]   region;
      logic [ID_W-1:0]   world;
      logic [HOUR_W-1:0] hour;
      logic [PEAK_W-1:0] count;
      logic [IDX_W-1:0]  eidx;
      logic [IDX_W-1:0]  sidx;
   } table_req_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_opcode;
   logic [15:0] req_region_id;
   logic [15:0] req_world_id;
   logic [4:0]  req_hour_of_day;
   logic [23:0] req_online_count;
   logic [4:0]  req_entry_index;
   logic [4:0]  req_slot_index;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_out_region;
   logic [15:0] rsp_out_world;
   logic [4:0]  rsp_out_hour;
   logic [23:0] rsp_out_peak;
   logic [5:0]  rsp_entries_used;

   result_type        awaited_results[$];
   int                fault_count = 0;
   int                hold_cycles = 0;
   bit                steady = 1'b0;

   int                tbl_used;
   logic [KEY_W-1:0]  tbl_key    [ENTRY_SLOTS];
   int                tbl_nslots [ENTRY_SLOTS];
   logic [HOUR_W-1:0] tbl_hour   [ENTRY_SLOTS][HOUR_SLOTS];
   logic [PEAK_W-1:0] tbl_peak   [ENTRY_SLOTS][HOUR_SLOTS];

   keyed_hourly_peak_table u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_region_id    (req_region_id),
      .req_world_id     (req_world_id),
      .req_hour_of_day  (req_hour_of_day),
      .req_online_count (req_online_count),
      .req_entry_index  (req_entry_index),
      .req_slot_index   (req_slot_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_out_region   (rsp_out_region),
      .rsp_out_world    (rsp_out_world),
      .rsp_out_hour     (rsp_out_hour),
      .rsp_out_peak     (rsp_out_peak),
      .rsp_entries_used (rsp_entries_used)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic result_type table_result(input table_req_type rq);
      result_type r;
      int         e;
      int         s;
      int         n;
      r = '0;
      r.status = ST_OK;
      case (rq.op)
         OP_RECORD: begin
            r.region = rq.region;
            r.world  = rq.world;
            r.hour   = rq.hour;
            e = -1;
            for (int i = 0; i < tbl_used; i++) begin
               if (e < 0 && tbl_nslots[i] > 0 && tbl_key[i] == {rq.region, rq.world})
                  e = i;
            end
            if (e < 0 && tbl_used >= ENTRY_SLOTS) begin
               r.status = ST_TABLE_FULL;
            end else begin
               if (e < 0) begin
                  e = tbl_used;
                  tbl_used++;
                  tbl_key[e]    = {rq.region, rq.world};
                  tbl_nslots[e] = 0;
               end
               n = tbl_nslots[e];
               s = -1;
               for (int i = 0; i < n; i++) begin
                  if (s < 0 && tbl_hour[e][i] == rq.hour)
                     s = i;
               end
               if (s >= 0) begin
                  if (tbl_peak[e][s] < rq.count)
                     tbl_peak[e][s] = rq.count;
                  r.peak = tbl_peak[e][s];
               end else if (n >= HOUR_SLOTS) begin
                  r.status = ST_SLOTS_FULL;
               end else begin
                  tbl_hour[e][n] = rq.hour;
                  tbl_peak[e][n] = rq.count;
                  tbl_nslots[e]  = n + 1;
                  r.peak         = rq.count;
               end
            end
         end
         OP_CLEAR: tbl_used = 0;
         OP_READ: begin
            e = int'(rq.eidx);
            s = int'(rq.sidx);
            if (e >= tbl_used || s >= tbl_nslots[e]) begin
               r.status = ST_READ_EMPTY;
            end else begin
               {r.region, r.world} = tbl_key[e];
               r.hour = tbl_hour[e][s];
               r.peak = tbl_peak[e][s];
            end
         end
         default: ;
      endcase
      r.used = USED_W'(tbl_used);
      return r;
   endfunction

   function automatic table_req_type make_req(input opcode_type op, input logic [15:0] region,
                                              input logic [15:0] world, input logic [4:0] hour,
                                              input logic [23:0] count, input logic [4:0] eidx,
                                              input logic [4:0] sidx);
      table_req_type rq;
      rq.op     = op;
      rq.region = region;
      rq.world  = world;
      rq.hour   = hour;
      rq.count  = count;
      rq.eidx   = eidx;
      rq.sidx   = sidx;
      return rq;
   endfunction

   function automatic logic [ID_W-1:0] random_id();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return ID_W'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic table_req_type random_req(input opcode_type op);
      table_req_type rq;
      rq.op     = op;
      rq.region = random_id();
      rq.world  = random_id();
      rq.hour   = HOUR_W'($urandom_range(0, 31));
      rq.count  = PEAK_W'($urandom_range(0, 24'hFFFFFF));
      rq.eidx   = IDX_W'($urandom_range(0, 31));
      rq.sidx   = IDX_W'($urandom_range(0, 31));
      return rq;
   endfunction

   task automatic note_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
      fault_count++;
   endtask

   task automatic send_request(input table_req_type rq);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 15);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= rq.op;
      req_region_id    <= rq.region;
      req_world_id     <= rq.world;
      req_hour_of_day  <= rq.hour;
      req_online_count <= rq.count;
      req_entry_index  <= rq.eidx;
      req_slot_index   <= rq.sidx;
      do @(posedge clock); while (req_ready !== 1'b1);
      awaited_results.push_back(table_result(rq));
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed_cases();
      send_request(make_req(OP_READ,   16'h0000, 16'h0000, 5'd0,  24'h000000, 5'd0,  5'd0));
      send_request(make_req(OP_NOP,    16'hFFFF, 16'hFFFF, 5'd31, 24'hFFFFFF, 5'd31, 5'd31));
      send_request(make_req(OP_RECORD, 16'hFFFF, 16'hFFFF, 5'd31, 24'hFFFFFF, 5'd0,  5'd0));
      send_request(make_req(OP_RECORD, 16'h0000, 16'h0000, 5'd0,  24'h000000, 5'd0,  5'd0));
      send_request(make_req(OP_RECORD, 16'h0000, 16'h0000, 5'd0,  24'h000005, 5'd0,  5'd0));
      send_request(make_req(OP_RECORD, 16'h0000, 16'h0000, 5'd0,  24'h000003, 5'd0,  5'd0));
      send_request(make_req(OP_RECORD, 16'h0000, 16'h0000, 5'd23, 24'h800000, 5'd0,  5'd0));
      send_request(make_req(OP_RECORD, 16'hFFFF, 16'hFFFF, 5'd31, 24'h000000, 5'd0,  5'd0));
      send_request(make_req(OP_RECORD, 16'h5555, 16'hAAAA, 5'd16, 24'h555555, 5'd0,  5'd0));
      send_request(make_req(OP_READ,   16'h0000, 16'h0000, 5'd0,  24'h000000, 5'd0,  5'd0));
      send_request(make_req(OP_READ,   16'h0000, 16'h0000, 5'd0,  24'h000000, 5'd1,  5'd0));
      send_request(make_req(OP_READ,   16'h0000, 16'h0000, 5'd0,  24'h000000, 5'd1,  5'd1));
      send_request(make_req(OP_READ,   16'h0000, 16'h0000, 5'd0,  24'h000000, 5'd1,  5'd2));
      send_request(make_req(OP_READ,   16'h0000, 16'h0000, 5'd0,  24'h000000, 5'd0,  5'd1));
      send_request(make_req(OP_READ,   16'h0000, 16'h0000, 5'd0,  24'h000000, 5'd2,  5'd0));
      send_request(make_req(OP_READ,   16'h0000, 16'h0000, 5'd0,  24'h000000, 5'd3,  5'd0));
      send_request(make_req(OP_READ,   16'h0000, 16'h0000, 5'd0,  24'h000000, 5'd31, 5'd23));
      send_request(make_req(OP_CLEAR,  16'hFFFF, 16'hFFFF, 5'd31, 24'hFFFFFF, 5'd31, 5'd31));
      send_request(make_req(OP_READ,   16'h0000, 16'h0000, 5'd0,  24'h000000, 5'd0,  5'd0));
      send_request(make_req(OP_RECORD, 16'hAAAA, 16'h5555, 5'd8,  24'hAAAAAA, 5'd0,  5'd0));
      send_request(make_req(OP_READ,   16'h0000, 16'h0000, 5'd0,  24'h000000, 5'd0,  5'd0));
      drain_results();
   endtask

   task automatic test_hour_slot_fill();
      int               order[32];
      int               j;
      int               t;
      logic [KEY_W-1:0] key;
      table_req_type    rq;
      for (int r = 0; r < 4; r++) begin
         send_request(random_req(OP_CLEAR));
         key = {random_id(), random_id()};
         for (int i = 0; i < 32; i++) order[i] = i;
         for (int i = 31; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
         end
         for (int i = 0; i < 40; i++) begin
            rq = random_req(OP_RECORD);
            {rq.region, rq.world} = key;
            rq.hour = HOUR_W'(i < 32 ? order[i] : order[$urandom_range(0, 31)]);
            send_request(rq);
         end
         repeat (8) begin
            rq = random_req(OP_READ);
            rq.eidx = IDX_W'($urandom_range(0, 1));
            send_request(rq);
         end
      end
      drain_results();
   endtask

   task automatic test_entry_table_fill();
      logic [KEY_W-1:0] keys[40];
      table_req_type    rq;
      for (int r = 0; r < 3; r++) begin
         send_request(random_req(OP_CLEAR));
         for (int i = 0; i < 40; i++) begin
            rq = random_req(OP_RECORD);
            keys[i] = i < 35 ? {rq.region, rq.world} : keys[$urandom_range(0, i - 1)];
            {rq.region, rq.world} = keys[i];
            rq.hour = HOUR_W'($urandom_range(0, 23));
            send_request(rq);
         end
         repeat (6) begin
            rq = random_req(OP_READ);
            rq.sidx = IDX_W'($urandom_range(0, 1));
            send_request(rq);
         end
      end
      drain_results();
   endtask

   task automatic test_output_stall();
      table_req_type rq;
      hold_cycles = 400;
      repeat (30) begin
         rq = random_req($urandom_range(0, 3) == 0 ? OP_READ : OP_RECORD);
         rq.region = ID_W'($urandom_range(0, 1));
         rq.world  = ID_W'($urandom_range(0, 1));
         rq.eidx   = IDX_W'($urandom_range(0, 3));
         rq.sidx   = IDX_W'($urandom_range(0, 3));
         send_request(rq);
      end
      drain_results();
   endtask

   task automatic test_random_traffic();
      logic [KEY_W-1:0] pool[40];
      int               pool_n;
      int               k;
      int               e;
      table_req_type    rq;
      for (int b = 0; b < 11; b++) begin
         steady = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 2))
            0:       pool_n = 3;
            1:       pool_n = 12;
            default: pool_n = 40;
         endcase
         for (int i = 0; i < pool_n; i++) pool[i] = {random_id(), random_id()};
         if ($urandom_range(0, 1) == 0) send_request(random_req(OP_CLEAR));
         for (int i = 0; i < 100; i++) begin
            k = $urandom_range(0, 99);
            if (k < 65) begin
               rq = random_req(OP_RECORD);
               {rq.region, rq.world} = pool[$urandom_range(0, pool_n - 1)];
               if ($urandom_range(0, 7) != 0) rq.hour = HOUR_W'($urandom_range(0, 23));
               if ($urandom_range(0, 1) == 0) rq.count = PEAK_W'($urandom_range(0, 40));
            end else if (k < 90) begin
               rq = random_req(OP_READ);
               if ($urandom_range(0, 4) != 0) begin
                  e = $urandom_range(0, tbl_used < 31 ? tbl_used + 1 : 31);
                  rq.eidx = IDX_W'(e);
                  rq.sidx = IDX_W'($urandom_range(0, tbl_nslots[e] < 31 ?
                                                     tbl_nslots[e] + 1 : 31));
               end
            end else if (k < 93) begin
               rq = random_req(OP_CLEAR);
            end else if (k < 96) begin
               rq = random_req(OP_NOP);
            end else begin
               rq = random_req(OP_RECORD);
            end
            send_request(rq);
         end
      end
      steady = 1'b0;
      drain_results();
   endtask

   initial begin
      int gap;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            gap = hold_cycles;
            hold_cycles = 0;
         end else begin
            gap = steady ? 0 : $urandom_range(0, 15);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && reset === 1'b0));
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (awaited_results.size() == 0) begin
            note_mismatch("response with none pending", 32'(rsp_status), 32'd0);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_status !== want.status)
               note_mismatch("status", 32'(rsp_status), 32'(want.status));
            if (rsp_out_region !== want.region)
               note_mismatch("region", 32'(rsp_out_region), 32'(want.region));
            if (rsp_out_world !== want.world)
               note_mismatch("world", 32'(rsp_out_world), 32'(want.world));
            if (rsp_out_hour !== want.hour)
               note_mismatch("hour", 32'(rsp_out_hour), 32'(want.hour));
            if (rsp_out_peak !== want.peak)
               note_mismatch("peak", 32'(rsp_out_peak), 32'(want.peak));
            if (rsp_entries_used !== want.used)
               note_mismatch("entries used", 32'(rsp_entries_used), 32'(want.used));
         end
      end
   end

   initial begin
      #10_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      tbl_used         = 0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_opcode       = OP_NOP;
      req_region_id    = '0;
      req_world_id     = '0;
      req_hour_of_day  = '0;
      req_online_count = '0;
      req_entry_index  = '0;
      req_slot_index   = '0;
      for (int i = 0; i < ENTRY_SLOTS; i++) tbl_nslots[i] = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_hour_slot_fill();
      test_entry_table_fill();
      test_output_stall();
      test_random_traffic();
      repeat (64) @(posedge clock);
      if (fault_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
